[design/dfa_pkg.sv]
package dfa_pkg;

    // Sizing of the mapper
    localparam int MAX_PIXELS     = 4096;
    localparam int MAX_UNIVERSES  = 32;    // at most 64 for the base tables below
    localparam int UNIVERSE_BYTES = 512;
    localparam int CONFIG_BYTES   = 20;
    localparam int COUNT_BYTES    = 16;
    localparam int DMX_SLOTS      = 512;   // slots per universe in the pixel address

    // Field widths
    localparam int UNIVERSE_W     = 15;
    localparam int VALUE_W        = 8;
    localparam int KIND_W         = 3;
    localparam int PIXEL_INDEX_W  = 12;
    localparam int COLOR_W        = 2;
    localparam int COUNT_W        = 32;
    localparam int PIXEL_COUNT_W  = 13;
    localparam int POS_W          = 10;

    // Derived widths
    localparam int UNI_IDX_W = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
    localparam int TOT_W     = $clog2(MAX_UNIVERSES + 1);
    localparam int EFF_W     = $clog2(MAX_PIXELS + 1);
    localparam int PIX_W     = $clog2(MAX_UNIVERSES * DMX_SLOTS);

    // Register port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_PIXEL_COUNT     = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_CONFIG_UNIVERSE = REG_IDX_W'(1);

    localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RST = PIXEL_COUNT_W'(4096);
    localparam logic [UNIVERSE_W-1:0]    CONFIG_UNI_RST  = UNIVERSE_W'(32767);

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_PIXEL     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CFG_OK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CFG_LEN   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CFG_SUM   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd5;

    typedef struct packed {
        logic [UNIVERSE_W-1:0] universe;
        logic [VALUE_W-1:0]    value;
        logic                  first_of_universe;
        logic                  last_of_universe;
    } byte_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [PIXEL_INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0]       color_channel;
        logic [VALUE_W-1:0]       pixel_value;
        logic [COUNT_W-1:0]       output_count_a;
        logic [COUNT_W-1:0]       output_count_b;
        logic [COUNT_W-1:0]       output_count_c;
        logic [COUNT_W-1:0]       output_count_d;
        logic                     last_result;
    } result_t;

    // u*512 = 3*170*u + 2*u; floor(2u/3) by reciprocal, exact for 2u below 128
    function automatic logic [7:0] third_of_twice(input logic [UNI_IDX_W-1:0] u);
        logic [15:0] twice;
        logic [15:0] prod;
        twice = 16'(u) << 1;
        prod  = twice * 16'd43;
        return 8'(prod >> 7);
    endfunction

    function automatic logic [PIX_W-1:0] base_pix(input logic [UNI_IDX_W-1:0] u);
        logic [31:0] acc;
        acc = 32'(u) * 32'd170 + 32'(third_of_twice(u));
        return PIX_W'(acc);
    endfunction

    function automatic logic [COLOR_W-1:0] base_col(input logic [UNI_IDX_W-1:0] u);
        logic [15:0] rem;
        rem = (16'(u) << 1) - 16'(third_of_twice(u)) * 16'd3;
        return COLOR_W'(rem);
    endfunction

endpackage

[design/dfa_byte_if.sv]
interface dfa_byte_if;
    import dfa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [UNIVERSE_W-1:0] universe;
    logic [VALUE_W-1:0]    value;
    logic                  first_of_universe;
    logic                  last_of_universe;

    modport source (
        output valid, universe, value, first_of_universe, last_of_universe,
        input  ready
    );
    modport sink (
        input  valid, universe, value, first_of_universe, last_of_universe,
        output ready
    );
endinterface

[design/dfa_result_if.sv]
interface dfa_result_if;
    import dfa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [PIXEL_INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0]       color_channel;
    logic [VALUE_W-1:0]       pixel_value;
    logic [COUNT_W-1:0]       output_count_a;
    logic [COUNT_W-1:0]       output_count_b;
    logic [COUNT_W-1:0]       output_count_c;
    logic [COUNT_W-1:0]       output_count_d;
    logic                     last_result;

    modport source (
        output valid, kind, pixel_index, color_channel, pixel_value,
               output_count_a, output_count_b, output_count_c, output_count_d,
               last_result,
        input  ready
    );
    modport sink (
        input  valid, kind, pixel_index, color_channel, pixel_value,
               output_count_a, output_count_b, output_count_c, output_count_d,
               last_result,
        output ready
    );
endinterface

[design/dmx_universe_frame_assembler.sv]
// DMX universe to RGB pixel mapper.
// payload: one DMX payload byte per item, with its universe number and the
//   first/last marks of the universe it belongs to.
// result: pixel channel writes, frame complete, output configuration status
//   and duplicate warnings; last_result marks the final result of a byte.
// APB port: register 0 pixel_count at byte address 0, register 1
//   config_universe at byte address 4; pready is tied high.
// An accepted byte is registered in the input stage and its results are
//   written from there to the result queue, which presents them in order.
// Throughput: one byte per cycle. A byte that both writes a pixel and closes
//   the frame yields two results, which leave the result port one at a time;
//   the four-entry result queue absorbs this, and payload.ready drops only
//   when the queue cannot take two more results.
// Reset clears the seen map, the byte mode (bytes before a first mark are
//   dropped), the queue and the registers to 4096 pixels and universe 32767.
// When the receiver stalls, results wait in the queue; bytes are still taken
//   until the queue holds more than two results, then payload.ready drops.
module dmx_universe_frame_assembler (
    input  logic                          clk,
    input  logic                          rst_n,
    dfa_byte_if.sink                      payload,
    dfa_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import dfa_pkg::*;

    localparam logic [1:0] MODE_IGNORE = 2'd0;
    localparam logic [1:0] MODE_PIXEL  = 2'd1;
    localparam logic [1:0] MODE_CONFIG = 2'd2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Register port
    logic [PIXEL_COUNT_W-1:0] pixel_count_reg;
    logic [UNIVERSE_W-1:0]    cfg_universe_reg;
    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_wr;

    // Mapper state
    logic [MAX_UNIVERSES-1:0] seen_reg, seen_next;
    logic [TOT_W-1:0]         seen_cnt_reg, seen_cnt_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [1:0]               mode_reg, mode_next;
    logic [PIX_W-1:0]         pix_reg, pix_next;
    logic [COLOR_W-1:0]       col_reg, col_next;
    logic [COUNT_W-1:0]       cfg_word_reg [4];
    logic [COUNT_W-1:0]       cfg_w4_reg;
    logic [COUNT_W-1:0]       sum_reg, sum_next;

    // Input stage
    logic  stg_valid_reg;
    byte_t stg_reg;
    logic  stg_fire;

    // Result queue
    result_t              fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   fifo_cnt_reg;
    logic                 pop;

    // Per-byte working values
    logic [EFF_W-1:0]     eff;
    logic [31:0]          tot_wide;
    logic [TOT_W-1:0]     total;
    logic [UNI_IDX_W-1:0] uni_idx;
    logic [POS_W-1:0]     pos_cur;
    logic [PIX_W-1:0]     pix_cur;
    logic [COLOR_W-1:0]   col_cur;
    logic                 cfg_byte_wr;
    logic                 pix_hit;
    result_t              res [2];
    logic [1:0]           n_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_PIXEL_COUNT:     prdata = APB_DATA_W'(pixel_count_reg);
            REG_CONFIG_UNIVERSE: prdata = APB_DATA_W'(cfg_universe_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg  <= PIXEL_COUNT_RST;
            cfg_universe_reg <= CONFIG_UNI_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_idx == REG_PIXEL_COUNT)
            begin
                pixel_count_reg <= pwdata[PIXEL_COUNT_W-1:0];
            end
            else if (reg_idx == REG_CONFIG_UNIVERSE)
            begin
                cfg_universe_reg <= pwdata[UNIVERSE_W-1:0];
            end
        end
    end

    // Pixels in use and the number of universes they span
    always_comb
    begin
        eff = (32'(pixel_count_reg) < 32'(MAX_PIXELS)) ? EFF_W'(pixel_count_reg)
                                                        : EFF_W'(MAX_PIXELS);
        tot_wide = (32'(eff) * 32'd3 + 32'd511) >> 9;
        total = (tot_wide > 32'(MAX_UNIVERSES)) ? TOT_W'(MAX_UNIVERSES)
                                                : TOT_W'(tot_wide);
    end

    // Input stage advances while the queue has room for two results
    assign stg_fire      = stg_valid_reg && (32'(fifo_cnt_reg) <= 32'(FIFO_DEPTH - 2));
    assign payload.ready = !stg_valid_reg || stg_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (payload.ready)
        begin
            stg_valid_reg <= payload.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (payload.ready && payload.valid)
        begin
            stg_reg.universe          <= payload.universe;
            stg_reg.value             <= payload.value;
            stg_reg.first_of_universe <= payload.first_of_universe;
            stg_reg.last_of_universe  <= payload.last_of_universe;
        end
    end

    assign uni_idx = stg_reg.universe[UNI_IDX_W-1:0];

    always_comb
    begin
        seen_next     = seen_reg;
        seen_cnt_next = seen_cnt_reg;
        mode_next     = mode_reg;
        pos_cur       = pos_reg;
        pix_cur       = pix_reg;
        col_cur       = col_reg;
        sum_next      = sum_reg;
        cfg_byte_wr   = 1'b0;
        pix_hit       = 1'b0;
        n_res         = 2'd0;
        res[0]        = '0;
        res[1]        = '0;

        if (stg_reg.first_of_universe)
        begin
            pos_cur = '0;
            pix_cur = base_pix(uni_idx);
            col_cur = base_col(uni_idx);
            if (stg_reg.universe == cfg_universe_reg)
            begin
                mode_next = MODE_CONFIG;
            end
            else if (32'(stg_reg.universe) >= 32'(total))
            begin
                mode_next = MODE_IGNORE;
            end
            else if (seen_reg[uni_idx])
            begin
                mode_next   = MODE_IGNORE;
                res[0].kind = KIND_DUPLICATE;
                n_res       = 2'd1;
            end
            else
            begin
                seen_next[uni_idx] = 1'b1;
                seen_cnt_next      = TOT_W'(seen_cnt_reg + 1'b1);
                mode_next          = MODE_PIXEL;
            end
        end

        unique case (mode_next)
            MODE_PIXEL:
            begin
                if ((32'(pos_cur) < 32'(UNIVERSE_BYTES)) && (32'(pix_cur) < 32'(eff)))
                begin
                    pix_hit              = 1'b1;
                    res[0].kind          = KIND_PIXEL;
                    res[0].pixel_index   = pix_cur[PIXEL_INDEX_W-1:0];
                    res[0].color_channel = col_cur;
                    res[0].pixel_value   = stg_reg.value;
                    n_res                = 2'd1;
                end
                if (stg_reg.last_of_universe && (seen_cnt_next == total))
                begin
                    if (pix_hit)
                    begin
                        res[1].kind = KIND_FRAME;
                        n_res       = 2'd2;
                    end
                    else
                    begin
                        res[0].kind = KIND_FRAME;
                        n_res       = 2'd1;
                    end
                    seen_next     = '0;
                    seen_cnt_next = '0;
                end
            end
            MODE_CONFIG:
            begin
                cfg_byte_wr = 32'(pos_cur) < 32'(CONFIG_BYTES);
                // Running sum of the four counts, restarted on the first byte
                sum_next = stg_reg.first_of_universe ? '0 : sum_reg;
                if (32'(pos_cur) < 32'(COUNT_BYTES))
                begin
                    sum_next = sum_next +
                               (COUNT_W'(stg_reg.value) << {pos_cur[1:0], 3'b000});
                end
                if (stg_reg.last_of_universe)
                begin
                    n_res = 2'd1;
                    if (32'(pos_cur) != 32'(CONFIG_BYTES - 1))
                    begin
                        res[0].kind = KIND_CFG_LEN;
                    end
                    else if (sum_next != {stg_reg.value, cfg_w4_reg[23:0]})
                    begin
                        res[0].kind = KIND_CFG_SUM;
                    end
                    else
                    begin
                        res[0].kind           = KIND_CFG_OK;
                        res[0].output_count_a = cfg_word_reg[0];
                        res[0].output_count_b = cfg_word_reg[1];
                        res[0].output_count_c = cfg_word_reg[2];
                        res[0].output_count_d = cfg_word_reg[3];
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (n_res == 2'd2)
        begin
            res[1].last_result = 1'b1;
        end
        else if (n_res == 2'd1)
        begin
            res[0].last_result = 1'b1;
        end

        pos_next = (pos_cur < POS_MAX) ? POS_W'(pos_cur + 1'b1) : pos_cur;
        if (col_cur == COLOR_W'(2))
        begin
            col_next = '0;
            pix_next = PIX_W'(pix_cur + 1'b1);
        end
        else
        begin
            col_next = COLOR_W'(col_cur + 1'b1);
            pix_next = pix_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            seen_cnt_reg <= '0;
            pos_reg      <= '0;
            mode_reg     <= MODE_IGNORE;
            pix_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            if (stg_fire)
            begin
                pos_reg      <= pos_next;
                mode_reg     <= mode_next;
                pix_reg      <= pix_next;
                col_reg      <= col_next;
            end
            // A new pixel count starts a fresh frame
            if (cfg_wr && (reg_idx == REG_PIXEL_COUNT))
            begin
                seen_reg     <= '0;
                seen_cnt_reg <= '0;
            end
            else if (stg_fire)
            begin
                seen_reg     <= seen_next;
                seen_cnt_reg <= seen_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_fire && cfg_byte_wr)
        begin
            sum_reg <= sum_next;
            if (32'(pos_cur) < 32'(COUNT_BYTES))
            begin
                cfg_word_reg[pos_cur[3:2]][{pos_cur[1:0], 3'b000} +: 8] <= stg_reg.value;
            end
            else
            begin
                cfg_w4_reg[{pos_cur[1:0], 3'b000} +: 8] <= stg_reg.value;
            end
        end
    end

    // Result queue: up to two pushes and one pop per cycle
    assign pop          = result.valid && result.ready;
    assign result.valid = (fifo_cnt_reg != '0);

    always_ff @(posedge clk)
    begin
        if (stg_fire && (n_res != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= res[0];
        end
        if (stg_fire && (n_res == 2'd2))
        begin
            fifo_mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= res[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            if (stg_fire)
            begin
                wr_ptr_reg <= FIFO_AW'(wr_ptr_reg + n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= FIFO_AW'(rd_ptr_reg + 1'b1);
            end
            fifo_cnt_reg <= FIFO_CW'(fifo_cnt_reg + (stg_fire ? FIFO_CW'(n_res) : '0)
                                     - FIFO_CW'(pop));
        end
    end

    always_comb
    begin
        result.kind           = fifo_mem[rd_ptr_reg].kind;
        result.pixel_index    = fifo_mem[rd_ptr_reg].pixel_index;
        result.color_channel  = fifo_mem[rd_ptr_reg].color_channel;
        result.pixel_value    = fifo_mem[rd_ptr_reg].pixel_value;
        result.output_count_a = fifo_mem[rd_ptr_reg].output_count_a;
        result.output_count_b = fifo_mem[rd_ptr_reg].output_count_b;
        result.output_count_c = fifo_mem[rd_ptr_reg].output_count_c;
        result.output_count_d = fifo_mem[rd_ptr_reg].output_count_d;
        result.last_result    = fifo_mem[rd_ptr_reg].last_result;
    end

endmodule

[design/dfa_checker.sv]
module dfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           res_valid,
    input logic                           res_ready,
    input logic [dfa_pkg::KIND_W-1:0]        res_kind,
    input logic [dfa_pkg::PIXEL_INDEX_W-1:0] res_pixel_index,
    input logic [dfa_pkg::VALUE_W-1:0]       res_value,
    input logic                           res_last,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [dfa_pkg::APB_ADDR_W-1:0]    paddr,
    input logic [dfa_pkg::APB_DATA_W-1:0]    pwdata,
    input logic [dfa_pkg::APB_DATA_W-1:0]    prdata
);
    import dfa_pkg::*;

    // Hold a stalled result unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
                                    $stable(res_pixel_index) && $stable(res_value))
        else $error("stalled result changed");

    // No result straight out of reset
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result present on leaving reset");

    // Frame complete always closes the results of its byte
    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_kind == KIND_FRAME) |-> res_last)
        else $error("frame complete not marked last");

    // A pixel count write reads back in the next cycle
    a_pixel_count_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && psel && penable && pwrite &&
         (paddr[APB_ADDR_W-1:2] == REG_PIXEL_COUNT))
        ##1 (psel && !pwrite && (paddr[APB_ADDR_W-1:2] == REG_PIXEL_COUNT))
        |-> prdata == APB_DATA_W'($past(pwdata[PIXEL_COUNT_W-1:0])))
        else $error("pixel count read back wrong");

endmodule

bind dmx_universe_frame_assembler dfa_checker u_dfa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_kind        (result.kind),
    .res_pixel_index (result.pixel_index),
    .res_value       (result.pixel_value),
    .res_last        (result.last_result),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);

[verif/dfa_check_pkg.sv]
`timescale 1ns / 100ps
package dfa_check_pkg;
    import dfa_pkg::*;

    localparam int POS_MAX = (1 << POS_W) - 1;

    typedef enum logic [1:0] {
        MODE_IGNORE,
        MODE_PIXEL,
        MODE_CONFIG
    } byte_mode_e;

    class pixel_map_scoreboard;
        logic [PIXEL_COUNT_W-1:0] pixel_count;
        logic [UNIVERSE_W-1:0]    config_universe;
        logic [MAX_UNIVERSES-1:0] universes_seen;
        int unsigned              seen_count;
        int unsigned              byte_pos;
        byte_mode_e               mode;
        logic [COUNT_W-1:0]       config_words [CONFIG_BYTES/4];
        logic [UNIVERSE_W-1:0]    current_universe;
        result_t                  expected_results [$];
        int unsigned              failures;
        int unsigned              bytes_taken;

        function new();
            pixel_count      = PIXEL_COUNT_RST;
            config_universe  = CONFIG_UNI_RST;
            universes_seen   = '0;
            seen_count       = 0;
            byte_pos         = 0;
            mode             = MODE_IGNORE;
            current_universe = '0;
            failures         = 0;
            bytes_taken      = 0;
            foreach (config_words[i])
                config_words[i] = '0;
        endfunction

        function int unsigned effective_pixels();
            return (int'(pixel_count) > MAX_PIXELS) ? MAX_PIXELS : int'(pixel_count);
        endfunction

        function int unsigned universe_count();
            int unsigned n;
            n = (effective_pixels() * 3 + DMX_SLOTS - 1) / DMX_SLOTS;
            return (n > MAX_UNIVERSES) ? MAX_UNIVERSES : n;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_PIXEL_COUNT)
            begin
                pixel_count    = data[PIXEL_COUNT_W-1:0];
                universes_seen = '0;
                seen_count     = 0;
            end
            else if (idx == REG_CONFIG_UNIVERSE)
                config_universe = data[UNIVERSE_W-1:0];
        endfunction

        function result_t status(logic [KIND_W-1:0] kind);
            result_t r;
            r      = '0;
            r.kind = kind;
            return r;
        endfunction

        function void take_byte(byte_t b);
            result_t            caused [$];
            result_t            r;
            int unsigned        pos;
            int unsigned        lin;
            logic [COUNT_W-1:0] sum;
            bytes_taken++;
            if (b.first_of_universe)
            begin
                current_universe = b.universe;
                byte_pos         = 0;
                if (b.universe == config_universe)
                    mode = MODE_CONFIG;
                else if (b.universe >= universe_count())
                    mode = MODE_IGNORE;
                else if (universes_seen[b.universe[UNI_IDX_W-1:0]])
                begin
                    mode = MODE_IGNORE;
                    caused.push_back(status(KIND_DUPLICATE));
                end
                else
                begin
                    universes_seen[b.universe[UNI_IDX_W-1:0]] = 1'b1;
                    seen_count++;
                    mode = MODE_PIXEL;
                end
            end
            pos = byte_pos;
            case (mode)
                MODE_PIXEL:
                begin
                    lin = current_universe * DMX_SLOTS + pos;
                    if (pos < UNIVERSE_BYTES && lin / 3 < effective_pixels())
                    begin
                        r               = status(KIND_PIXEL);
                        r.pixel_index   = PIXEL_INDEX_W'(lin / 3);
                        r.color_channel = COLOR_W'(lin % 3);
                        r.pixel_value   = b.value;
                        caused.push_back(r);
                    end
                    if (b.last_of_universe && seen_count == universe_count())
                    begin
                        caused.push_back(status(KIND_FRAME));
                        universes_seen = '0;
                        seen_count     = 0;
                    end
                end
                MODE_CONFIG:
                begin
                    if (pos < CONFIG_BYTES)
                        config_words[pos/4][8*(pos%4) +: 8] = b.value;
                    if (b.last_of_universe)
                    begin
                        if (pos + 1 != CONFIG_BYTES)
                            caused.push_back(status(KIND_CFG_LEN));
                        else
                        begin
                            sum = config_words[0] + config_words[1]
                                + config_words[2] + config_words[3];
                            if (sum != config_words[4])
                                caused.push_back(status(KIND_CFG_SUM));
                            else
                            begin
                                r                = status(KIND_CFG_OK);
                                r.output_count_a = config_words[0];
                                r.output_count_b = config_words[1];
                                r.output_count_c = config_words[2];
                                r.output_count_d = config_words[3];
                                caused.push_back(r);
                            end
                        end
                    end
                end
                default: ;
            endcase
            // hold the position once it saturates
            if (pos < POS_MAX)
                byte_pos = pos + 1;
            if (caused.size() > 0)
            begin
                r             = caused.pop_back();
                r.last_result = 1'b1;
                caused.push_back(r);
            end
            foreach (caused[i])
                expected_results.push_back(caused[i]);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: kind %0d pix %0d col %0d val %02h",
                             got.kind, got.pixel_index, got.color_channel, got.pixel_value);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind || got.pixel_index !== want.pixel_index
                || got.color_channel !== want.color_channel
                || got.pixel_value !== want.pixel_value
                || got.output_count_a !== want.output_count_a
                || got.output_count_b !== want.output_count_b
                || got.output_count_c !== want.output_count_c
                || got.output_count_d !== want.output_count_d
                || got.last_result !== want.last_result)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch: kind %0d/%0d pix %0d/%0d col %0d/%0d val %02h/%02h",
                             want.kind, got.kind, want.pixel_index, got.pixel_index,
                             want.color_channel, got.color_channel,
                             want.pixel_value, got.pixel_value);
                    $display("  last %0b/%0b counts %h %h %h %h / %h %h %h %h",
                             want.last_result, got.last_result,
                             want.output_count_a, want.output_count_b,
                             want.output_count_c, want.output_count_d,
                             got.output_count_a, got.output_count_b,
                             got.output_count_c, got.output_count_d);
                end
            end
        endfunction
    endclass

endpackage

[verif/dmx_universe_frame_assembler_test.sv]
`timescale 1ns / 100ps
module dmx_universe_frame_assembler_test;
    import dfa_pkg::*;
    import dfa_check_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;
    localparam int ITEMS       = 950;
    localparam int CLOSE_BYTES = UNIVERSE_BYTES + 6;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dfa_byte_if   payload_bus ();
    dfa_result_if result_bus ();

    pixel_map_scoreboard board;
    bit                  sender_gaps;
    bit                  receiver_stalls;
    bit                  hold_request;
    int unsigned         quiet_cycles;

    dmx_universe_frame_assembler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .payload (payload_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic byte_t make_byte(input int unsigned uni, input int unsigned val,
                                        input bit first, input bit last);
        byte_t b;
        b.universe          = UNIVERSE_W'(uni);
        b.value             = VALUE_W'(val);
        b.first_of_universe = first;
        b.last_of_universe  = last;
        return b;
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 4);
        else if (r < 98)
            return $urandom_range(5, 24);
        return $urandom_range(25, 120);
    endfunction

    task automatic send_byte(input byte_t b);
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            payload_bus.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        payload_bus.valid             = 1'b1;
        payload_bus.universe          = b.universe;
        payload_bus.value             = b.value;
        payload_bus.first_of_universe = b.first_of_universe;
        payload_bus.last_of_universe  = b.last_of_universe;
        do
            @(posedge clk);
        while (!payload_bus.ready);
        board.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_universe(input int unsigned uni, input int len);
        for (int i = 0; i < len; i++)
            send_byte(make_byte((i == 0) ? uni : $urandom, $urandom, i == 0, i == len - 1));
    endtask

    // bytes without a first mark continue in whatever mode the last universe left
    task automatic send_noise(input int len);
        for (int i = 0; i < len; i++)
            send_byte(make_byte($urandom, $urandom, 1'b0, $urandom_range(0, 7) == 0));
    endtask

    task automatic send_config_bytes(input int unsigned uni,
                                     input logic [8*CONFIG_BYTES-1:0] image, input int len);
        int unsigned val;
        for (int i = 0; i < len; i++)
        begin
            val = (i < CONFIG_BYTES) ? image[8*i +: 8] : $urandom;
            send_byte(make_byte((i == 0) ? uni : $urandom, val, i == 0, i == len - 1));
        end
    endtask

    task automatic send_config(input int unsigned uni);
        logic [COUNT_W-1:0] counts [4];
        logic [COUNT_W-1:0] sum;
        int                 len;
        sum = '0;
        foreach (counts[i])
        begin
            case ($urandom_range(0, 3))
                0:       counts[i] = '0;
                1:       counts[i] = '1;
                default: counts[i] = $urandom;
            endcase
            sum += counts[i];
        end
        len = CONFIG_BYTES;
        case ($urandom_range(0, 9))
            6, 7: sum ^= COUNT_W'(1) << $urandom_range(0, COUNT_W - 1);
            8, 9:
            begin
                len = $urandom_range(1, 2 * CONFIG_BYTES);
                if (len == CONFIG_BYTES)
                    len++;
            end
            default: ;
        endcase
        send_config_bytes(uni, {sum, counts[3], counts[2], counts[1], counts[0]}, len);
    endtask

    // one pass over every pixel universe in random order, with repeats,
    // out-of-range universes, configuration and stray bytes mixed in
    task automatic send_frame();
        int order [$];
        int sent [$];
        int tot;
        int j;
        int tmp;
        tot = board.universe_count();
        for (int i = 0; i < tot; i++)
            order.push_back(i);
        for (int i = tot - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[k])
        begin
            case ($urandom_range(0, 19))
                0:
                    if (sent.size() > 0)
                        send_universe(sent[$urandom_range(0, sent.size() - 1)],
                                      $urandom_range(1, 3));
                1: send_universe($urandom_range(tot, CONFIG_UNI_RST), $urandom_range(1, 6));
                2: send_config(board.config_universe);
                3: send_noise($urandom_range(1, 3));
                default: ;
            endcase
            send_universe(order[k], pick_length());
            sent.push_back(order[k]);
        end
        if (tot == 0)
        begin
            repeat (3) send_universe($urandom_range(0, MAX_UNIVERSES - 1), pick_length());
            send_config(board.config_universe);
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = APB_ADDR_W'({idx, 2'b00});
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_register(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // stop offering, wait for every expected result, then let the pipe settle
    task automatic drain();
        payload_bus.valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        result_bus.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                result_bus.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 3) == 0)
            begin
                result_bus.ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            else
            begin
                result_bus.ready = 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : collect_results
        result_t got;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            got.kind           = result_bus.kind;
            got.pixel_index    = result_bus.pixel_index;
            got.color_channel  = result_bus.color_channel;
            got.pixel_value    = result_bus.pixel_value;
            got.output_count_a = result_bus.output_count_a;
            got.output_count_b = result_bus.output_count_b;
            got.output_count_c = result_bus.output_count_c;
            got.output_count_d = result_bus.output_count_d;
            got.last_result    = result_bus.last_result;
            board.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((payload_bus.valid && payload_bus.ready)
                || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("** dmx_universe_frame_assembler: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned pc_value;
        int unsigned cfg_value;
        int          phase;
        board                         = new();
        quiet_cycles                  = 0;
        rst_n                         = 1'b0;
        psel                          = 1'b0;
        penable                       = 1'b0;
        pwrite                        = 1'b0;
        paddr                         = '0;
        pwdata                        = '0;
        payload_bus.valid             = 1'b0;
        payload_bus.universe          = '0;
        payload_bus.value             = '0;
        payload_bus.first_of_universe = 1'b0;
        payload_bus.last_of_universe  = 1'b0;
        sender_gaps                   = 1'b0;
        receiver_stalls               = 1'b0;
        hold_request                  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing has opened a universe yet, so this byte is dropped
        send_byte(make_byte($urandom, 8'h00, 1'b0, 1'b0));
        send_byte(make_byte(0, 8'hFF, 1'b1, 1'b1));
        send_byte(make_byte(0, 8'h5A, 1'b1, 1'b1));
        send_universe(board.universe_count(), 2);
        // counts sum wraps past 32 bits
        send_config_bytes(CONFIG_UNI_RST, {32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                           32'h0000_0001, 32'hFFFF_FFFF}, CONFIG_BYTES);
        drain();
        write_reg(REG_PIXEL_COUNT, 1);
        // single byte both writes the pixel and closes the frame
        send_byte(make_byte(0, 8'h00, 1'b1, 1'b1));
        drain();

        write_reg(REG_PIXEL_COUNT, MAX_PIXELS);
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        // long receiver hold-off while bytes keep coming
        hold_request    = 1'b1;
        send_frame();

        phase = 1;
        while (phase <= 2 || board.bytes_taken + CLOSE_BYTES < ITEMS)
        begin
            drain();
            case (phase)
                1: pc_value = 0;
                2: pc_value = (1 << PIXEL_COUNT_W) - 1;
                default:
                    case ($urandom_range(0, 9))
                        0:       pc_value = 0;
                        1:       pc_value = (1 << PIXEL_COUNT_W) - 1;
                        2:       pc_value = MAX_PIXELS;
                        3:       pc_value = $urandom_range(0, (1 << PIXEL_COUNT_W) - 1);
                        default: pc_value = $urandom_range(1, 700);
                    endcase
            endcase
            if (phase == 2)
                cfg_value = 0;
            else
                case ($urandom_range(0, 7))
                    0:       cfg_value = 0;
                    1:       cfg_value = CONFIG_UNI_RST;
                    2, 3:    cfg_value = $urandom_range(0, MAX_UNIVERSES - 1);
                    default: cfg_value = $urandom_range(0, CONFIG_UNI_RST);
                endcase
            write_reg(REG_PIXEL_COUNT, pc_value);
            write_reg(REG_CONFIG_UNIVERSE, cfg_value);
            sender_gaps     = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
            send_frame();
            phase++;
        end

        // closing stretch without idling: run the byte position past the channel limit
        drain();
        write_reg(REG_PIXEL_COUNT, MAX_PIXELS);
        write_reg(REG_CONFIG_UNIVERSE, CONFIG_UNI_RST);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        send_universe(5, CLOSE_BYTES);
        drain();

        if (board.failures == 0)
            $display("** dmx_universe_frame_assembler: PASSED **");
        else
            $display("** dmx_universe_frame_assembler: FAILED **");
        $finish;
    end

endmodule
